/* rtl/scd_pkg.sv */
// scd_pkg: shared types, constants and helpers of the prefix-shared code decoder.
// No dependencies; used by scd_ctrl, scd_datapath and prefix_shared_code_decoder.
package scd_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 4;
  localparam int LEN_W      = 5;
  localparam int ENTRY_W    = 5;
  localparam int CNT_W      = 32;
  localparam int VAL_W      = 9;
  localparam int SUM_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RECORD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_RECORD  = 2'd2;

  localparam logic [LEN_W-1:0] CODE_LENGTH_RST  = 5'd16;
  localparam logic [CNT_W-1:0] FIRST_RECORD_RST = 32'd1;
  localparam logic [CNT_W-1:0] LAST_RECORD_RST  = 32'hFFFF_FFFF;

  // b/17 == (b*241) >> 12 for every 8-bit b
  localparam int DIV17_MUL   = 241;
  localparam int DIV17_SHIFT = 12;
  localparam int DIV17_PW    = 16;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic emit_start;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic fin_emit;
    logic out_free;
    logic emit_last;
  } status_t;

  // len*(len+1)/2, at most 136 for len <= 16
  function automatic logic [SUM_W-1:0] tri_num(input logic [LEN_W-1:0] len);
    logic [2*LEN_W:0] prod;
    prod = {6'b0, len} * ({6'b0, len} + 11'd1);
    return prod[SUM_W:1];
  endfunction

endpackage

/* rtl/scd_ctrl.sv */
// scd_ctrl: controller of the decoder, byte intake and entry emission sequencing.
// Depends on scd_pkg (state_t, cmd_t, status_t).
module scd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  scd_pkg::status_t status,
  output scd_pkg::cmd_t    cmd
);

  scd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd.take_byte  = 1'b0;
    cmd.emit_start = 1'b0;
    cmd.emit_load  = 1'b0;
    unique case (state_r)
      scd_pkg::ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.take_byte = 1'b1;
          if (status.fin_emit) begin
            cmd.emit_start = 1'b1;
            state_nxt      = scd_pkg::ST_EMIT;
          end
        end
      end
      scd_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            state_nxt = scd_pkg::ST_IDLE;
          end
        end
      end
    endcase
  end

endmodule

/* rtl/scd_datapath.sv */
// scd_datapath: config registers, entry store, record state, sum and output register.
// Depends on scd_pkg; driven by scd_ctrl through cmd_t / status_t.
module scd_datapath #(
  parameter int MAX_ENTRIES = scd_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [scd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [scd_pkg::BYTE_W-1:0]       in_byte,
  input  scd_pkg::cmd_t                    cmd,
  output scd_pkg::status_t                 status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [scd_pkg::CNT_W-1:0]        out_record_number,
  output logic [scd_pkg::POS_W-1:0]        out_entry_index,
  output logic signed [scd_pkg::VAL_W-1:0] out_entry_value,
  output logic                             out_last_entry
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [scd_pkg::LEN_W-1:0] MAX_LEN = scd_pkg::LEN_W'(MAX_ENTRIES);

  logic [scd_pkg::LEN_W-1:0]   code_length_r;
  logic [scd_pkg::CNT_W-1:0]   first_record_r;
  logic [scd_pkg::CNT_W-1:0]   last_record_r;

  logic [scd_pkg::ENTRY_W-1:0] store_r [MAX_ENTRIES];
  logic [scd_pkg::POS_W-1:0]   fill_r;
  logic                        expect_r;
  logic [scd_pkg::CNT_W-1:0]   cnt_r;
  logic [scd_pkg::POS_W-1:0]   emit_pos_r;
  logic [scd_pkg::SUM_W-1:0]   sum_r;

  logic                        out_valid_r;
  logic [scd_pkg::CNT_W-1:0]   out_rec_r;
  logic [scd_pkg::POS_W-1:0]   out_idx_r;
  logic [scd_pkg::VAL_W-1:0]   out_val_r;
  logic                        out_last_r;

  logic [scd_pkg::LEN_W-1:0]      len, len_m1, drop_ext, off;
  logic [scd_pkg::DIV17_PW-1:0]   prod17;
  logic [scd_pkg::POS_W-1:0]      drop, pos_p1;
  logic [scd_pkg::LEN_W:0]        pos_ext, len_ext;
  logic                           hdr_fin, dat_fin, finish, wr_hi, wr_lo, in_win;
  logic [scd_pkg::CNT_W-1:0]      cnt_eff;
  logic [IDX_W-1:0]               wr_idx_hi, wr_idx_lo, rd_idx;
  logic [scd_pkg::ENTRY_W-1:0]    rd_entry, nib_hi, nib_lo;
  logic [scd_pkg::SUM_W-1:0]      last_v, val8;
  logic                           emit_last;

  // configuration, ready whenever out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_length_r  <= scd_pkg::CODE_LENGTH_RST;
      first_record_r <= scd_pkg::FIRST_RECORD_RST;
      last_record_r  <= scd_pkg::LAST_RECORD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scd_pkg::CFG_CODE_LENGTH:  code_length_r  <= cfg_data[scd_pkg::LEN_W-1:0];
        scd_pkg::CFG_FIRST_RECORD: first_record_r <= cfg_data;
        scd_pkg::CFG_LAST_RECORD:  last_record_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (code_length_r == '0) begin
      len = scd_pkg::LEN_W'(1);
    end else if (code_length_r > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = code_length_r;
    end
    len_m1 = len - scd_pkg::LEN_W'(1);

    // header: drop = byte / 17
    prod17   = {8'b0, in_byte} * scd_pkg::DIV17_PW'(scd_pkg::DIV17_MUL);
    drop     = prod17[scd_pkg::DIV17_SHIFT +: scd_pkg::POS_W];
    drop_ext = {1'b0, drop};
    off      = (drop_ext > len_m1) ? '0 : len_m1 - drop_ext;
    hdr_fin  = (off >= len_m1);

    // nibble pair
    pos_ext = {2'b0, fill_r};
    len_ext = {1'b0, len};
    wr_hi   = (pos_ext + 6'd1) < len_ext;
    wr_lo   = (pos_ext + 6'd2) < len_ext;
    dat_fin = (pos_ext + 6'd2) >= {1'b0, len_m1};
    pos_p1  = fill_r + 4'd1;
    wr_idx_hi = fill_r[IDX_W-1:0];
    wr_idx_lo = pos_p1[IDX_W-1:0];
    nib_hi  = {1'b0, in_byte[7:4]} + 5'd1;
    nib_lo  = {1'b0, in_byte[3:0]} + 5'd1;

    finish  = expect_r ? hdr_fin : dat_fin;
    cnt_eff = expect_r ? cnt_r + 32'd1 : cnt_r;
    in_win  = (cnt_eff >= first_record_r) && (cnt_eff <= last_record_r);

    // emission
    rd_idx    = emit_pos_r[IDX_W-1:0];
    rd_entry  = store_r[rd_idx];
    emit_last = ({1'b0, emit_pos_r} == len_m1);
    last_v    = scd_pkg::tri_num(len) - sum_r;
    val8      = emit_last ? last_v : {3'b0, rd_entry};

    status.fin_emit  = finish && in_win;
    status.out_free  = !out_valid_r || out_ready;
    status.emit_last = emit_last;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && !expect_r) begin
      if (wr_hi) begin
        store_r[wr_idx_hi] <= nib_hi;
      end
      if (wr_lo) begin
        store_r[wr_idx_lo] <= nib_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      expect_r   <= 1'b1;
      cnt_r      <= '0;
      emit_pos_r <= '0;
      sum_r      <= '0;
    end else begin
      if (cmd.take_byte) begin
        cnt_r <= cnt_eff;
        if (finish) begin
          fill_r   <= '0;
          expect_r <= 1'b1;
        end else if (expect_r) begin
          fill_r   <= off[scd_pkg::POS_W-1:0];
          expect_r <= 1'b0;
        end else begin
          fill_r <= fill_r + 4'd2;
        end
      end
      if (cmd.emit_start) begin
        emit_pos_r <= '0;
        sum_r      <= '0;
      end else if (cmd.emit_load) begin
        emit_pos_r <= emit_last ? '0 : emit_pos_r + 4'd1;
        sum_r      <= sum_r + {3'b0, rd_entry};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_rec_r  <= cnt_r;
      out_idx_r  <= emit_pos_r;
      out_val_r  <= {val8, 1'b0};
      out_last_r <= emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_record_number = out_rec_r;
  assign out_entry_index   = out_idx_r;
  assign out_entry_value   = out_val_r;
  assign out_last_entry    = out_last_r;

  a_hdr_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    expect_r |-> fill_r == '0)
    else $error("fill position not cleared while waiting for a header");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> {1'b0, emit_pos_r} <= len_m1)
    else $error("emit position beyond record length");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load && emit_last |=> out_valid_r && out_last_r)
    else $error("final entry not flagged");

  a_no_take_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> !cmd.take_byte)
    else $error("byte taken during emission");

endmodule

/* rtl/prefix_shared_code_decoder.sv */
// Prefix-shared code decoder: header/nibble byte stream in, doubled record entries out.
// Each request is taken while idle; a request that completes a record inside the
// window then blocks input while its L entries (L = record length) leave,
// one per cycle through the output register, slower if out_ready stalls.
// The first entry goes through ST_EMIT, then the output register. rst_n (sync) clears
// config to defaults and record state, ready is low in reset; the entry store is left as is.
module prefix_shared_code_decoder #(
  parameter int MAX_ENTRIES = scd_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [scd_pkg::BYTE_W-1:0]       in_byte_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [scd_pkg::CNT_W-1:0]        out_record_number,
  output logic [scd_pkg::POS_W-1:0]        out_entry_index,
  output logic signed [scd_pkg::VAL_W-1:0] out_entry_value,
  output logic                             out_last_entry
);

  scd_pkg::cmd_t    cmd;
  scd_pkg::status_t status;

  assign cfg_ready = rst_n;

  scd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  scd_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_byte           (in_byte_in),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_record_number (out_record_number),
    .out_entry_index   (out_entry_index),
    .out_entry_value   (out_entry_value),
    .out_last_entry    (out_last_entry)
  );

endmodule
